// ===== rtl/core/smsat_pkg.sv =====
// shared types and constants of the shadow-map summed-area table unit
// depends on nothing; used by the interfaces and the top level
package smsat_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int DEPTH_BITS = 16;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int SIZE_W = 11;

	localparam int COUNT_W = 21;
	localparam int DSUM_W  = 36;
	localparam int SQSUM_W = 52;

	localparam int RUN_COUNT_W = 11;
	localparam int RUN_DEPTH_W = 26;
	localparam int RUN_SQ_W    = 42;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = CFG_IDX_W'(2);

	localparam logic [SIZE_W-1:0]     FRAME_WIDTH_RST  = SIZE_W'(1024);
	localparam logic [SIZE_W-1:0]     FRAME_HEIGHT_RST = SIZE_W'(1024);
	localparam logic [DEPTH_BITS-1:0] THRESHOLD_RST    = DEPTH_BITS'(1);

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [DSUM_W-1:0]  depth;
		logic [SQSUM_W-1:0] square;
	} entry_t;

endpackage

// ===== rtl/core/smsat_sample_if.sv =====
// input channel of the summed-area table unit: one depth sample per request
// depends on smsat_pkg
interface smsat_sample_if;
	logic                             valid;
	logic                             ready;
	logic [smsat_pkg::DEPTH_BITS-1:0] depth_sample;

	modport source (output valid, output depth_sample, input ready);
	modport sink (input valid, input depth_sample, output ready);
endinterface

// ===== rtl/core/smsat_result_if.sv =====
// output channel of the summed-area table unit: three table values and frame end
// depends on smsat_pkg
interface smsat_result_if;
	logic                          valid;
	logic                          ready;
	logic [smsat_pkg::COUNT_W-1:0] count_sum;
	logic [smsat_pkg::DSUM_W-1:0]  depth_sum;
	logic [smsat_pkg::SQSUM_W-1:0] depth_square_sum;
	logic                          frame_end;

	modport source (output valid, output count_sum, output depth_sum,
		output depth_square_sum, output frame_end, input ready);
	modport sink (input valid, input count_sum, input depth_sum,
		input depth_square_sum, input frame_end, output ready);
endinterface

// ===== rtl/core/smsat_cfg_if.sv =====
// configuration write channel of the summed-area table unit
// depends on smsat_pkg
interface smsat_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [smsat_pkg::CFG_IDX_W-1:0]  index;
	logic [smsat_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/shadow_moment_summed_area_table_unit.sv =====
// top level of the shadow-map summed-area table unit, with its row buffer
// depends on smsat_pkg, smsat_sample_if, smsat_result_if, smsat_cfg_if
//
// Takes one depth sample per request in raster order and returns, per pixel, the
// summed-area count of samples above the threshold, the sum of depths and the sum
// of squared depths. It sustains one sample per clock unless the output stalls:
// the row buffer is a single memory with one read port (read when a sample is
// accepted) and one write port (written when the pixel's result is formed), and
// the read-modify-write of one column overlaps the next samples through forwarding,
// so narrow frames run at full rate too. A sample's result passes stages 1 and 2
// before the output register. The row buffer needs no clearing after reset; the
// first row of every frame ignores it. Frame size and threshold must be written
// only while idle, unenforced by the block; a write does not restart the frame.
module shadow_moment_summed_area_table_unit (
	input logic            clk,
	input logic            arst_n,
	smsat_sample_if.sink   sample,
	smsat_result_if.source result,
	smsat_cfg_if.sink      cfg
);

	// configuration registers
	logic [smsat_pkg::SIZE_W-1:0]     frame_width_q;
	logic [smsat_pkg::SIZE_W-1:0]     frame_height_q;
	logic [smsat_pkg::DEPTH_BITS-1:0] threshold_q;

	// raster position of the next sample
	logic [smsat_pkg::COL_W-1:0] col_q;
	logic [smsat_pkg::ROW_W-1:0] row_q;

	logic [smsat_pkg::COL_W-1:0] last_col;
	logic [smsat_pkg::ROW_W-1:0] last_row;
	logic [smsat_pkg::COL_W-1:0] col_now;
	logic                        row_last;
	logic                        frame_last;

	logic acc_in;
	logic adv_s1;
	logic adv_s2;
	logic wr_en;

	// stage 1: sample accepted, row buffer read in flight
	logic                             v_s1;
	logic [smsat_pkg::DEPTH_BITS-1:0] d_s1;
	logic                             occ_s1;
	logic [smsat_pkg::COL_W-1:0]      col_s1;
	logic                             first_s1;
	logic                             rownz_s1;
	logic                             last_s1;
	logic                             byp_s1;
	smsat_pkg::entry_t                byp_data_s1;
	smsat_pkg::entry_t                mem_rd_q;
	smsat_pkg::entry_t                above_eff;

	// row running sums, valid for the pixel in stage 2
	logic [smsat_pkg::RUN_COUNT_W-1:0] run_count_q;
	logic [smsat_pkg::RUN_DEPTH_W-1:0] run_depth_q;
	logic [smsat_pkg::RUN_SQ_W-1:0]    run_sq_q;
	logic [smsat_pkg::RUN_COUNT_W-1:0] run_count_nx;
	logic [smsat_pkg::RUN_DEPTH_W-1:0] run_depth_nx;
	logic [smsat_pkg::RUN_SQ_W-1:0]    run_sq_nx;
	logic [2*smsat_pkg::DEPTH_BITS-1:0] d_square;

	// stage 2: table value formed and written back
	logic                        v_s2;
	logic [smsat_pkg::COL_W-1:0] col_s2;
	logic                        rownz_s2;
	logic                        last_s2;
	smsat_pkg::entry_t           above_s2;
	smsat_pkg::entry_t           sum_entry;

	// output register
	logic              out_valid_q;
	smsat_pkg::entry_t out_entry_q;
	logic              out_last_q;

	smsat_pkg::entry_t row_mem [smsat_pkg::MAX_WIDTH];

	// configuration port
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= smsat_pkg::FRAME_WIDTH_RST;
			frame_height_q <= smsat_pkg::FRAME_HEIGHT_RST;
			threshold_q    <= smsat_pkg::THRESHOLD_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				smsat_pkg::REG_FRAME_WIDTH: begin
					frame_width_q <= cfg.data[smsat_pkg::SIZE_W-1:0];
				end
				smsat_pkg::REG_FRAME_HEIGHT: begin
					frame_height_q <= cfg.data[smsat_pkg::SIZE_W-1:0];
				end
				smsat_pkg::REG_THRESHOLD: begin
					threshold_q <= cfg.data[smsat_pkg::DEPTH_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// clamped last column and row; zero size acts as one
	always_comb begin
		if (frame_width_q == '0) begin
			last_col = '0;
		end else if (frame_width_q > smsat_pkg::SIZE_W'(smsat_pkg::MAX_WIDTH)) begin
			last_col = smsat_pkg::COL_W'(smsat_pkg::MAX_WIDTH - 1);
		end else begin
			last_col = smsat_pkg::COL_W'(frame_width_q - smsat_pkg::SIZE_W'(1));
		end
		if (frame_height_q == '0) begin
			last_row = '0;
		end else if (frame_height_q > smsat_pkg::SIZE_W'(smsat_pkg::MAX_HEIGHT)) begin
			last_row = smsat_pkg::ROW_W'(smsat_pkg::MAX_HEIGHT - 1);
		end else begin
			last_row = smsat_pkg::ROW_W'(frame_height_q - smsat_pkg::SIZE_W'(1));
		end
	end

	// width shrunk mid-row: this pixel closes the row
	assign col_now    = (col_q > last_col) ? last_col : col_q;
	assign row_last   = (col_now == last_col);
	assign frame_last = row_last && (row_q >= last_row);

	// handshakes
	assign adv_s2       = v_s2 && (!out_valid_q || result.ready);
	assign wr_en        = adv_s2;
	assign adv_s1       = v_s1 && (!v_s2 || adv_s2);
	assign sample.ready = !v_s1 || adv_s1;
	assign acc_in       = sample.valid && sample.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc_in) begin
			if (frame_last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_last) begin
				col_q <= '0;
				row_q <= row_q + smsat_pkg::ROW_W'(1);
			end else begin
				col_q <= col_now + smsat_pkg::COL_W'(1);
			end
		end
	end

	// row buffer: one read at accept, one write at stage 2
	always_ff @(posedge clk) begin
		if (wr_en) begin
			row_mem[col_s2] <= sum_entry;
		end
		if (acc_in) begin
			mem_rd_q <= row_mem[col_now];
		end
	end

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc_in) begin
			v_s1 <= 1'b1;
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			d_s1        <= sample.depth_sample;
			occ_s1      <= (sample.depth_sample > threshold_q);
			col_s1      <= col_now;
			first_s1    <= (col_now == '0);
			rownz_s1    <= (row_q != '0);
			last_s1     <= frame_last;
			// write to the same column in this cycle is missed by the read
			byp_s1      <= wr_en && (col_s2 == col_now);
			byp_data_s1 <= sum_entry;
		end else if (v_s1 && wr_en && (col_s2 == col_s1)) begin
			byp_s1      <= 1'b1;
			byp_data_s1 <= sum_entry;
		end
	end

	assign above_eff = byp_s1 ? byp_data_s1 : mem_rd_q;

	assign d_square = d_s1 * d_s1;

	always_comb begin
		if (first_s1) begin
			run_count_nx = smsat_pkg::RUN_COUNT_W'(occ_s1);
			run_depth_nx = smsat_pkg::RUN_DEPTH_W'(d_s1);
			run_sq_nx    = smsat_pkg::RUN_SQ_W'(d_square);
		end else begin
			run_count_nx = run_count_q + smsat_pkg::RUN_COUNT_W'(occ_s1);
			run_depth_nx = run_depth_q + smsat_pkg::RUN_DEPTH_W'(d_s1);
			run_sq_nx    = run_sq_q + smsat_pkg::RUN_SQ_W'(d_square);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_count_q <= '0;
			run_depth_q <= '0;
			run_sq_q    <= '0;
		end else if (adv_s1) begin
			run_count_q <= run_count_nx;
			run_depth_q <= run_depth_nx;
			run_sq_q    <= run_sq_nx;
		end
	end

	// stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s1) begin
			v_s2 <= 1'b1;
		end else if (adv_s2) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			col_s2   <= col_s1;
			rownz_s2 <= rownz_s1;
			last_s2  <= last_s1;
			// the pixel leaving stage 2 now may write the column we need
			if (wr_en && (col_s2 == col_s1)) begin
				above_s2 <= sum_entry;
			end else begin
				above_s2 <= above_eff;
			end
		end
	end

	always_comb begin
		sum_entry.count  = smsat_pkg::COUNT_W'(run_count_q);
		sum_entry.depth  = smsat_pkg::DSUM_W'(run_depth_q);
		sum_entry.square = smsat_pkg::SQSUM_W'(run_sq_q);
		if (rownz_s2) begin
			sum_entry.count  = smsat_pkg::COUNT_W'(run_count_q) + above_s2.count;
			sum_entry.depth  = smsat_pkg::DSUM_W'(run_depth_q) + above_s2.depth;
			sum_entry.square = smsat_pkg::SQSUM_W'(run_sq_q) + above_s2.square;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s2) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			out_entry_q <= sum_entry;
			out_last_q  <= last_s2;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.count_sum        = out_entry_q.count;
	assign result.depth_sum        = out_entry_q.depth;
	assign result.depth_square_sum = out_entry_q.square;
	assign result.frame_end        = out_last_q;

endmodule
